@@ rtl/sfsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsd_pkg
// Shared types, command codes and direction tables of the stroke decoder.
// ----------------------------------------------------------------------------
package sfsd_pkg;

	localparam int unsigned COORD_W     = 16;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned STACK_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;

	localparam logic [COORD_W-1:0] ORIGIN_X_RST = 16'd200;
	localparam logic [COORD_W-1:0] ORIGIN_Y_RST = 16'd300;

	// command codes (low nibble of a byte whose high nibble is zero)
	localparam logic [3:0] CMD_END       = 4'd0;
	localparam logic [3:0] CMD_PEN_DOWN  = 4'd1;
	localparam logic [3:0] CMD_PEN_UP    = 4'd2;
	localparam logic [3:0] CMD_SCALE_DIV = 4'd3;
	localparam logic [3:0] CMD_SCALE_MUL = 4'd4;
	localparam logic [3:0] CMD_PUSH      = 4'd5;
	localparam logic [3:0] CMD_POP       = 4'd6;
	localparam logic [3:0] CMD_SUBSHAPE  = 4'd7;
	localparam logic [3:0] CMD_XY        = 4'd8;
	localparam logic [3:0] CMD_XY_SEQ    = 4'd9;
	localparam logic [3:0] CMD_OCT_ARC   = 4'd10;
	localparam logic [3:0] CMD_FRAC_ARC  = 4'd11;
	localparam logic [3:0] CMD_BULGE_ARC = 4'd12;
	localparam logic [3:0] CMD_BULGE_SEQ = 4'd13;
	localparam logic [3:0] CMD_SKIP      = 4'd14;
	localparam logic [3:0] CMD_NOP       = 4'd15;

	localparam logic [1:0] REP_NONE   = 2'd0;
	localparam logic [1:0] REP_PAIR   = 2'd1;
	localparam logic [1:0] REP_TRIPLE = 2'd2;

	localparam logic [2:0] OPS_ZERO  = 3'd0;
	localparam logic [2:0] OPS_ONE   = 3'd1;
	localparam logic [2:0] OPS_TWO   = 3'd2;
	localparam logic [2:0] OPS_THREE = 3'd3;
	localparam logic [2:0] OPS_FIVE  = 3'd5;

	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_DRAW = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic               pen_down;
		logic [3:0]         pend_cmd;
		logic [2:0]         ops_left;
		logic [15:0]        hold;
		logic [1:0]         rep_mode;
		logic               skip;
		logic               ended;
	} sfsd_state_t;

	typedef struct packed {
		logic               valid;
		logic               kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} sfsd_result_t;

	function automatic sfsd_state_t clear_state(input logic [COORD_W-1:0] ox,
		input logic [COORD_W-1:0] oy);
		sfsd_state_t s;
		s       = '0;
		s.pos_x = ox;
		s.pos_y = oy;
		return s;
	endfunction

	// half-unit step of each of the sixteen vector directions
	function automatic logic signed [2:0] dir_dx(input logic [3:0] d);
		logic signed [2:0] v;
		case (d)
			4'd0, 4'd1, 4'd2, 4'd14, 4'd15: v = 3'sd2;
			4'd3, 4'd13:                    v = 3'sd1;
			4'd4, 4'd12:                    v = 3'sd0;
			4'd5, 4'd11:                    v = -3'sd1;
			default:                        v = -3'sd2;
		endcase
		return v;
	endfunction

	function automatic logic signed [2:0] dir_dy(input logic [3:0] d);
		logic signed [2:0] v;
		case (d)
			4'd2, 4'd3, 4'd4, 4'd5, 4'd6:     v = 3'sd2;
			4'd1, 4'd7:                       v = 3'sd1;
			4'd0, 4'd8:                       v = 3'sd0;
			4'd9, 4'd15:                      v = -3'sd1;
			default:                          v = -3'sd2;
		endcase
		return v;
	endfunction

endpackage

@@ rtl/sfsd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfsd_decode
// Next-state and stroke logic for one definition byte.
// ----------------------------------------------------------------------------
module sfsd_decode #(
	parameter int unsigned STACK_DEPTH = sfsd_pkg::STACK_DEPTH,
	parameter int unsigned CNT_W       = $clog2(STACK_DEPTH + 1)
) (
	input  sfsd_pkg::sfsd_state_t           state_q,
	input  logic [CNT_W-1:0]                stack_count_q,
	input  logic [7:0]                      shape_byte,
	input  logic                            last_byte,
	input  logic [sfsd_pkg::COORD_W-1:0]    origin_x,
	input  logic [sfsd_pkg::COORD_W-1:0]    origin_y,
	input  logic [2*sfsd_pkg::COORD_W-1:0]  pop_data,
	output sfsd_pkg::sfsd_state_t           state_n,
	output logic [CNT_W-1:0]                stack_count_n,
	output logic                            push_en,
	output sfsd_pkg::sfsd_result_t          result
);

	logic signed [2:0]  ddx;
	logic signed [2:0]  ddy;
	logic signed [4:0]  len_s;
	logic signed [7:0]  vec_dx;
	logic signed [7:0]  vec_dy;
	logic [15:0]        hold_sh;
	logic [2:0]         left_dec;

	assign ddx      = sfsd_pkg::dir_dx(shape_byte[3:0]);
	assign ddy      = sfsd_pkg::dir_dy(shape_byte[3:0]);
	assign len_s    = {1'b0, shape_byte[7:4]};
	assign vec_dx   = ddx * len_s;
	assign vec_dy   = ddy * len_s;
	assign hold_sh  = {state_q.hold[7:0], shape_byte};
	assign left_dec = state_q.ops_left - 3'd1;

	always_comb begin
		sfsd_pkg::sfsd_state_t nx;
		logic        do_vec;
		logic        res_v;
		logic        res_kind;
		logic [8:0]  vdx;
		logic [8:0]  vdy;
		logic        skip;

		nx            = state_q;
		stack_count_n = stack_count_q;
		push_en       = 1'b0;
		do_vec        = 1'b0;
		res_v         = 1'b0;
		res_kind      = sfsd_pkg::KIND_MOVE;
		vdx           = {hold_sh[15:8], 1'b0};
		vdy           = {hold_sh[7:0], 1'b0};
		skip          = state_q.skip;

		if (!state_q.ended) begin
			if (state_q.ops_left != sfsd_pkg::OPS_ZERO) begin
				// operand byte
				nx.hold     = hold_sh;
				nx.ops_left = left_dec;
				if (state_q.rep_mode == sfsd_pkg::REP_TRIPLE && left_dec == sfsd_pkg::OPS_ONE
						&& hold_sh == 16'd0) begin
					// zero pair ends a bulge series
					nx.rep_mode = sfsd_pkg::REP_NONE;
					nx.ops_left = sfsd_pkg::OPS_ZERO;
					nx.skip     = 1'b0;
				end else if (left_dec != sfsd_pkg::OPS_ZERO) begin
					nx.skip = skip;
				end else if (state_q.rep_mode == sfsd_pkg::REP_PAIR) begin
					if (hold_sh == 16'd0) begin
						nx.rep_mode = sfsd_pkg::REP_NONE;
						nx.skip     = 1'b0;
					end else begin
						do_vec      = !skip;
						nx.ops_left = sfsd_pkg::OPS_TWO;
						nx.hold     = '0;
					end
				end else if (state_q.rep_mode == sfsd_pkg::REP_TRIPLE) begin
					nx.ops_left = sfsd_pkg::OPS_THREE;
					nx.hold     = '0;
				end else begin
					do_vec      = (state_q.pend_cmd == sfsd_pkg::CMD_XY) && !skip;
					nx.pend_cmd = sfsd_pkg::CMD_END;
					nx.skip     = 1'b0;
				end
			end else begin
				// command byte
				nx.skip = 1'b0;
				if (shape_byte[7:4] != 4'd0) begin
					do_vec = !skip;
					vdx    = {vec_dx[7], vec_dx};
					vdy    = {vec_dy[7], vec_dy};
				end else begin
					case (shape_byte[3:0])
						sfsd_pkg::CMD_END: begin
							nx.ended = 1'b1;
						end
						sfsd_pkg::CMD_PEN_DOWN: begin
							if (!skip) begin
								nx.pen_down = 1'b1;
								res_v       = 1'b1;
							end
						end
						sfsd_pkg::CMD_PEN_UP: begin
							if (!skip) begin
								nx.pen_down = 1'b0;
							end
						end
						sfsd_pkg::CMD_SCALE_DIV, sfsd_pkg::CMD_SCALE_MUL: begin
							nx.pend_cmd = shape_byte[3:0];
							nx.ops_left = sfsd_pkg::OPS_ONE;
							nx.hold     = '0;
							nx.skip     = skip;
						end
						sfsd_pkg::CMD_PUSH: begin
							if (!skip && stack_count_q < CNT_W'(STACK_DEPTH)) begin
								push_en       = 1'b1;
								stack_count_n = stack_count_q + 1'b1;
							end
						end
						sfsd_pkg::CMD_POP: begin
							if (!skip && stack_count_q != '0) begin
								stack_count_n = stack_count_q - 1'b1;
								nx.pos_x      = pop_data[2*sfsd_pkg::COORD_W-1:sfsd_pkg::COORD_W];
								nx.pos_y      = pop_data[sfsd_pkg::COORD_W-1:0];
								res_v         = state_q.pen_down;
							end
						end
						sfsd_pkg::CMD_XY, sfsd_pkg::CMD_XY_SEQ, sfsd_pkg::CMD_OCT_ARC: begin
							nx.pend_cmd = shape_byte[3:0];
							nx.ops_left = sfsd_pkg::OPS_TWO;
							nx.hold     = '0;
							nx.skip     = skip;
							if (shape_byte[3:0] == sfsd_pkg::CMD_XY_SEQ) begin
								nx.rep_mode = sfsd_pkg::REP_PAIR;
							end
						end
						sfsd_pkg::CMD_BULGE_SEQ, sfsd_pkg::CMD_BULGE_ARC: begin
							nx.pend_cmd = shape_byte[3:0];
							nx.ops_left = sfsd_pkg::OPS_THREE;
							nx.hold     = '0;
							nx.skip     = skip;
							if (shape_byte[3:0] == sfsd_pkg::CMD_BULGE_SEQ) begin
								nx.rep_mode = sfsd_pkg::REP_TRIPLE;
							end
						end
						sfsd_pkg::CMD_FRAC_ARC: begin
							nx.pend_cmd = shape_byte[3:0];
							nx.ops_left = sfsd_pkg::OPS_FIVE;
							nx.hold     = '0;
							nx.skip     = skip;
						end
						sfsd_pkg::CMD_SKIP: begin
							nx.skip = !skip;
						end
						default: begin
							// subshape and no-op codes do nothing
						end
					endcase
				end
			end
		end

		// shape y points up, screen y points down
		if (do_vec) begin
			nx.pos_x = state_q.pos_x + {{7{vdx[8]}}, vdx};
			nx.pos_y = state_q.pos_y - {{7{vdy[8]}}, vdy};
			res_v    = state_q.pen_down;
			res_kind = sfsd_pkg::KIND_DRAW;
		end

		result.valid = res_v;
		result.kind  = res_kind;
		result.x     = nx.pos_x;
		result.y     = nx.pos_y;

		if (last_byte) begin
			nx            = sfsd_pkg::clear_state(origin_x, origin_y);
			stack_count_n = '0;
		end

		state_n = nx;
	end

endmodule

@@ rtl/shape_font_stroke_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_font_stroke_decoder_unit
// Turns a stream of vector glyph definition bytes into pen moves and lines.
// ----------------------------------------------------------------------------
// usage
//  shape channel: one definition byte per transfer (shape_byte, last_byte),
//    taken at a clock edge with shape_valid high and shape_stall low
//  stroke channel: at most one stroke per byte (stroke_kind, point_x, point_y),
//    taken at a clock edge with stroke_valid high and stroke_stall low
//  config port: cfg_wr_en with cfg_index 0 (origin_x) or 1 (origin_y) writes
//    the glyph start point; other indexes are dropped; write only when idle
//  output: a stroke is registered into the stroke register, or into the skid register while the receiver stalls
//  throughput: one byte per cycle while shape_stall is low; the decode is a single combinational pass
//    from the state registers back to themselves and to the output buffer
//  stall: a two-entry output buffer (stroke register plus skid register)
//    lets one stroke more through after the receiver stalls; shape_stall rises
//    only once the skid register holds a stroke
//  reset: origin returns to (200, 300), position to the origin, pen up,
//    stack empty, no stroke pending; after a last byte the same clear runs
//    with the programmed origin
// ----------------------------------------------------------------------------
module shape_font_stroke_decoder_unit #(
	parameter int unsigned STACK_DEPTH = sfsd_pkg::STACK_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// shape byte channel
	input  logic                                 shape_valid,
	output logic                                 shape_stall,
	input  logic [7:0]                           shape_byte,
	input  logic                                 last_byte,
	// stroke channel
	output logic                                 stroke_valid,
	input  logic                                 stroke_stall,
	output logic                                 stroke_kind,
	output logic signed [sfsd_pkg::COORD_W-1:0]  point_x,
	output logic signed [sfsd_pkg::COORD_W-1:0]  point_y,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [sfsd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// configuration registers
	logic [sfsd_pkg::COORD_W-1:0] origin_x_q;
	logic [sfsd_pkg::COORD_W-1:0] origin_y_q;

	// decoder state
	sfsd_pkg::sfsd_state_t        state_q;
	sfsd_pkg::sfsd_state_t        state_n;
	logic [CNT_W-1:0]             stack_count_q;
	logic [CNT_W-1:0]             stack_count_n;
	logic [CNT_W-1:0]             count_dec;
	logic                         push_en;
	sfsd_pkg::sfsd_result_t       result;

	// position stack, no reset: entries are read only after a push
	logic [2*sfsd_pkg::COORD_W-1:0] stack_mem [STACK_DEPTH];
	logic [2*sfsd_pkg::COORD_W-1:0] pop_data;

	// output buffer
	logic                         out_valid_q;
	logic                         out_kind_q;
	logic [sfsd_pkg::COORD_W-1:0] out_x_q;
	logic [sfsd_pkg::COORD_W-1:0] out_y_q;
	logic                         skid_valid_q;
	logic                         skid_kind_q;
	logic [sfsd_pkg::COORD_W-1:0] skid_x_q;
	logic [sfsd_pkg::COORD_W-1:0] skid_y_q;

	logic                         shape_xfer;
	logic                         out_free;
	logic                         new_stroke;

	assign shape_stall = skid_valid_q;
	assign shape_xfer  = shape_valid && !skid_valid_q;
	assign out_free    = !out_valid_q || !stroke_stall;
	assign new_stroke  = shape_xfer && result.valid;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= sfsd_pkg::ORIGIN_X_RST;
			origin_y_q <= sfsd_pkg::ORIGIN_Y_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == sfsd_pkg::REG_ORIGIN_X) begin
				origin_x_q <= cfg_data;
			end
			if (cfg_index == sfsd_pkg::REG_ORIGIN_Y) begin
				origin_y_q <= cfg_data;
			end
		end
	end

	// top of stack sits one below the fill count
	assign count_dec = stack_count_q - 1'b1;
	assign pop_data  = stack_mem[count_dec[IDX_W-1:0]];

	sfsd_decode #(
		.STACK_DEPTH (STACK_DEPTH),
		.CNT_W       (CNT_W)
	) u_decode (
		.state_q       (state_q),
		.stack_count_q (stack_count_q),
		.shape_byte    (shape_byte),
		.last_byte     (last_byte),
		.origin_x      (origin_x_q),
		.origin_y      (origin_y_q),
		.pop_data      (pop_data),
		.state_n       (state_n),
		.stack_count_n (stack_count_n),
		.push_en       (push_en),
		.result        (result)
	);

	// state advances once per byte transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= sfsd_pkg::clear_state(sfsd_pkg::ORIGIN_X_RST,
				sfsd_pkg::ORIGIN_Y_RST);
			stack_count_q <= '0;
		end else if (shape_xfer) begin
			state_q       <= state_n;
			stack_count_q <= stack_count_n;
		end
	end

	always_ff @(posedge clk) begin
		if (shape_xfer && push_en) begin
			stack_mem[stack_count_q[IDX_W-1:0]] <= {state_q.pos_x, state_q.pos_y};
		end
	end

	// output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			// no byte is taken while the skid register is full
			if (out_free) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (out_free) begin
			out_valid_q <= new_stroke;
		end else if (new_stroke) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_free) begin
				out_kind_q <= skid_kind_q;
				out_x_q    <= skid_x_q;
				out_y_q    <= skid_y_q;
			end
		end else if (out_free) begin
			if (new_stroke) begin
				out_kind_q <= result.kind;
				out_x_q    <= result.x;
				out_y_q    <= result.y;
			end
		end else if (new_stroke) begin
			skid_kind_q <= result.kind;
			skid_x_q    <= result.x;
			skid_y_q    <= result.y;
		end
	end

	assign stroke_valid = out_valid_q;
	assign stroke_kind  = out_kind_q;
	assign point_x      = $signed(out_x_q);
	assign point_y      = $signed(out_y_q);

endmodule

@@ tb/sv/stroke_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stroke_checker
// Watches the shape, stroke and configuration ports of the stroke decoder,
// works out every stroke from the accepted bytes and compares them in order.
// ----------------------------------------------------------------------------
module stroke_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shape_valid,
	input  logic                                shape_stall,
	input  logic [7:0]                          shape_byte,
	input  logic                                last_byte,
	input  logic                                stroke_valid,
	input  logic                                stroke_stall,
	input  logic                                stroke_kind,
	input  logic signed [sfsd_pkg::COORD_W-1:0] point_x,
	input  logic signed [sfsd_pkg::COORD_W-1:0] point_y,
	input  logic                                cfg_wr_en,
	input  logic [sfsd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sfsd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                final_check,
	output int                                  fail_count,
	output int                                  strokes_checked,
	output int                                  strokes_due
);
	import sfsd_pkg::*;

	typedef struct {
		logic                      kind;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} stroke_t;

	// half-unit step per direction, shape y pointing up
	localparam int STEP_X [16] = '{2, 2, 2, 1, 0, -1, -2, -2, -2, -2, -2, -1, 0, 1, 2, 2};
	localparam int STEP_Y [16] = '{0, 1, 2, 2, 2, 2, 2, 1, 0, -1, -2, -2, -2, -2, -2, -1};

	stroke_t              stroke_q [$];
	stroke_t              want;
	logic [COORD_W-1:0]   origin_x;
	logic [COORD_W-1:0]   origin_y;
	logic [COORD_W-1:0]   cur_x;
	logic [COORD_W-1:0]   cur_y;
	logic                 pen_down;
	logic                 skip_cmd;
	logic                 glyph_done;
	logic [3:0]           wait_cmd;
	logic [2:0]           ops_left;
	logic [15:0]          op_bytes;
	logic [1:0]           rep_mode;
	logic [2*COORD_W-1:0] saved_pos [STACK_DEPTH];
	int unsigned          saved_count;
	logic                 leftover_checked;

	function automatic void restart_glyph();
		cur_x       = origin_x;
		cur_y       = origin_y;
		pen_down    = 1'b0;
		skip_cmd    = 1'b0;
		glyph_done  = 1'b0;
		wait_cmd    = CMD_END;
		ops_left    = OPS_ZERO;
		op_bytes    = '0;
		rep_mode    = REP_NONE;
		saved_count = 0;
	endfunction

	function automatic void add_stroke(input logic kind);
		stroke_t s;
		s.kind = kind;
		s.x    = cur_x;
		s.y    = cur_y;
		stroke_q.push_back(s);
	endfunction

	// screen y grows downwards
	function automatic void move_pen(input logic [COORD_W-1:0] dx, input logic [COORD_W-1:0] dy);
		cur_x = cur_x + dx;
		cur_y = cur_y - dy;
		if (pen_down)
			add_stroke(KIND_DRAW);
	endfunction

	function automatic logic [COORD_W-1:0] to_half(input logic [7:0] v);
		return {{7{v[7]}}, v, 1'b0};
	endfunction

	function automatic void take_operand(input logic [7:0] b);
		op_bytes = {op_bytes[7:0], b};
		ops_left = ops_left - OPS_ONE;
		if (rep_mode == REP_TRIPLE && ops_left == OPS_ONE && op_bytes == 16'h0000) begin
			// zero pair closes a bulge series, no bulge byte follows
			rep_mode = REP_NONE;
			ops_left = OPS_ZERO;
			skip_cmd = 1'b0;
		end else if (ops_left == OPS_ZERO) begin
			if (rep_mode == REP_PAIR) begin
				if (op_bytes == 16'h0000) begin
					rep_mode = REP_NONE;
					skip_cmd = 1'b0;
				end else begin
					if (!skip_cmd)
						move_pen(to_half(op_bytes[15:8]), to_half(op_bytes[7:0]));
					ops_left = OPS_TWO;
					op_bytes = '0;
				end
			end else if (rep_mode == REP_TRIPLE) begin
				ops_left = OPS_THREE;
				op_bytes = '0;
			end else begin
				if (wait_cmd == CMD_XY && !skip_cmd)
					move_pen(to_half(op_bytes[15:8]), to_half(op_bytes[7:0]));
				wait_cmd = CMD_END;
				skip_cmd = 1'b0;
			end
		end
	endfunction

	function automatic void collect(input logic [3:0] code, input logic [2:0] count,
		input logic skipped);
		wait_cmd = code;
		ops_left = count;
		op_bytes = '0;
		skip_cmd = skipped;
	endfunction

	function automatic void take_command(input logic [7:0] b);
		logic skipped;
		skipped  = skip_cmd;
		skip_cmd = 1'b0;
		if (b[7:4] != 4'h0) begin
			if (!skipped)
				move_pen(16'(STEP_X[b[3:0]] * int'(b[7:4])), 16'(STEP_Y[b[3:0]] * int'(b[7:4])));
		end else begin
			case (b[3:0])
				CMD_END:       glyph_done = 1'b1;
				CMD_PEN_DOWN: begin
					if (!skipped) begin
						pen_down = 1'b1;
						add_stroke(KIND_MOVE);
					end
				end
				CMD_PEN_UP:    if (!skipped) pen_down = 1'b0;
				CMD_SCALE_DIV, CMD_SCALE_MUL: collect(b[3:0], OPS_ONE, skipped);
				CMD_PUSH: begin
					if (!skipped && saved_count < STACK_DEPTH) begin
						saved_pos[saved_count] = {cur_x, cur_y};
						saved_count++;
					end
				end
				CMD_POP: begin
					if (!skipped && saved_count > 0) begin
						saved_count--;
						{cur_x, cur_y} = saved_pos[saved_count];
						if (pen_down)
							add_stroke(KIND_MOVE);
					end
				end
				CMD_XY, CMD_OCT_ARC: collect(b[3:0], OPS_TWO, skipped);
				CMD_XY_SEQ: begin
					collect(b[3:0], OPS_TWO, skipped);
					rep_mode = REP_PAIR;
				end
				CMD_BULGE_SEQ: begin
					collect(b[3:0], OPS_THREE, skipped);
					rep_mode = REP_TRIPLE;
				end
				CMD_FRAC_ARC:  collect(b[3:0], OPS_FIVE, skipped);
				CMD_BULGE_ARC: collect(b[3:0], OPS_THREE, skipped);
				CMD_SKIP:      skip_cmd = !skipped;
				default:       ;
			endcase
		end
	endfunction

	function automatic void decode_shape_byte(input logic [7:0] b, input logic last);
		if (!glyph_done) begin
			if (ops_left != OPS_ZERO)
				take_operand(b);
			else
				take_command(b);
		end
		if (last)
			restart_glyph();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x = ORIGIN_X_RST;
			origin_y = ORIGIN_Y_RST;
			restart_glyph();
			stroke_q.delete();
			fail_count       = 0;
			strokes_checked  = 0;
			leftover_checked = 1'b0;
		end else begin
			// strokes are registered after their byte is taken, so compare first
			if (stroke_valid && !stroke_stall) begin
				if (stroke_q.size() == 0) begin
					$error("unexpected stroke: kind %0d x %0d y %0d", stroke_kind, point_x,
						point_y);
					fail_count++;
				end else begin
					want = stroke_q.pop_front();
					if (stroke_kind !== want.kind) begin
						$error("stroke_kind: expected %0d, actual %0d", want.kind, stroke_kind);
						fail_count++;
					end
					if (point_x !== want.x) begin
						$error("point_x: expected %0d, actual %0d", want.x, point_x);
						fail_count++;
					end
					if (point_y !== want.y) begin
						$error("point_y: expected %0d, actual %0d", want.y, point_y);
						fail_count++;
					end
					strokes_checked++;
				end
			end
			if (shape_valid && !shape_stall)
				decode_shape_byte(shape_byte, last_byte);
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_ORIGIN_X: origin_x = cfg_data;
					REG_ORIGIN_Y: origin_y = cfg_data;
					default:      ;
				endcase
			end
			if (final_check && !leftover_checked) begin
				leftover_checked = 1'b1;
				if (stroke_q.size() != 0) begin
					$error("%0d expected strokes never arrived", stroke_q.size());
					fail_count++;
				end
			end
		end
		strokes_due = stroke_q.size();
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives glyph definition bytes into the stroke decoder over several origin
// settings, with bursty transfers and a stalling receiver; the stroke checker
// beside the block predicts and compares every stroke.
// ----------------------------------------------------------------------------
module testbench;
	import sfsd_pkg::*;

	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int DRAIN_LIMIT     = 20000;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_pattern_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  shape_valid  = 1'b0;
	logic                  shape_stall;
	logic [7:0]            shape_byte   = '0;
	logic                  last_byte    = 1'b0;
	logic                  stroke_valid;
	logic                  stroke_stall = 1'b0;
	logic                  stroke_kind;
	logic signed [15:0]    point_x;
	logic signed [15:0]    point_y;
	logic                  cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  final_check  = 1'b0;

	int fail_count;
	int strokes_checked;
	int strokes_due;

	logic [7:0]     glyph_q [$];
	int unsigned    burst_left   = 1;
	int unsigned    bytes_sent   = 0;
	int unsigned    glyphs_sent  = 0;
	int unsigned    settings_run = 1;
	stall_pattern_t stall_pattern = STALL_NONE;
	int unsigned    stall_run     = 0;
	int unsigned    beat          = 0;

	shape_font_stroke_decoder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.shape_valid  (shape_valid),
		.shape_stall  (shape_stall),
		.shape_byte   (shape_byte),
		.last_byte    (last_byte),
		.stroke_valid (stroke_valid),
		.stroke_stall (stroke_stall),
		.stroke_kind  (stroke_kind),
		.point_x      (point_x),
		.point_y      (point_y),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	stroke_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.shape_valid     (shape_valid),
		.shape_stall     (shape_stall),
		.shape_byte      (shape_byte),
		.last_byte       (last_byte),
		.stroke_valid    (stroke_valid),
		.stroke_stall    (stroke_stall),
		.stroke_kind     (stroke_kind),
		.point_x         (point_x),
		.point_y         (point_y),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.final_check     (final_check),
		.fail_count      (fail_count),
		.strokes_checked (strokes_checked),
		.strokes_due     (strokes_due)
	);

	// 12 ns period
	always #6 clk = ~clk;

	// receiver back-pressure: a pattern held for a random run, then another one
	always @(negedge clk) begin
		if (stall_run == 0) begin
			stall_pattern = stall_pattern_t'($urandom_range(0, 3));
			stall_run     = $urandom_range(20, 200);
		end else begin
			stall_run--;
		end
		beat++;
		case (stall_pattern)
			STALL_NONE:  stroke_stall = 1'b0;
			STALL_LIGHT: stroke_stall = ($urandom_range(0, 3) == 0);
			STALL_HEAVY: stroke_stall = ($urandom_range(0, 9) != 0);
			default:     stroke_stall = beat[2];
		endcase
	end

	// hard stop in case the handshake locks up
	initial begin
		#10ms;
		$display("Simulation FAILED");
		$finish;
	end

	// one byte transfer; the sender runs in bursts with random gaps in between
	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		shape_valid = 1'b1;
		shape_byte  = b;
		last_byte   = last;
		do
			@(posedge clk);
		while (shape_stall);
		bytes_sent++;
		burst_left--;
		if (burst_left == 0) begin
			@(negedge clk);
			shape_valid = 1'b0;
			repeat ($urandom_range(0, 6))
				@(negedge clk);
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
	endtask

	// hold the sender off until every stroke owed has left the block
	task automatic settle();
		@(negedge clk);
		shape_valid = 1'b0;
		while (strokes_due != 0)
			@(negedge clk);
		// bytes without a stroke may still be in flight
		repeat (4)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic play_glyph();
		foreach (glyph_q[i])
			send_byte(glyph_q[i], i == glyph_q.size() - 1);
		glyphs_sent++;
	endtask

	function automatic void add_pair(input logic nonzero);
		logic [7:0] dx;
		logic [7:0] dy;
		do begin
			dx = 8'($urandom);
			dy = 8'($urandom);
		end while (nonzero && dx == 8'h00 && dy == 8'h00);
		glyph_q.push_back(dx);
		glyph_q.push_back(dy);
	endfunction

	// a glyph of random commands with their operands, closed by an end code
	// most of the time; a few are plain noise or stop in the middle of a command
	function automatic void compose_glyph();
		int unsigned pick;
		int unsigned arc;
		glyph_q.delete();
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 24))
				glyph_q.push_back(8'($urandom));
			return;
		end
		if ($urandom_range(0, 3) != 0)
			glyph_q.push_back(8'(CMD_PEN_DOWN));
		repeat ($urandom_range(0, 16)) begin
			pick = $urandom_range(0, 19);
			if (pick <= 6) begin
				glyph_q.push_back(8'($urandom_range(16, 255)));
			end else if (pick == 7) begin
				glyph_q.push_back(8'(CMD_PEN_DOWN));
			end else if (pick == 8) begin
				glyph_q.push_back(8'(CMD_PEN_UP));
			end else if (pick == 9) begin
				glyph_q.push_back(8'(CMD_PUSH));
			end else if (pick == 10) begin
				glyph_q.push_back(8'(CMD_POP));
			end else if (pick == 11) begin
				glyph_q.push_back(8'(CMD_XY));
				add_pair(1'b0);
			end else if (pick == 12) begin
				glyph_q.push_back(8'(CMD_XY_SEQ));
				repeat ($urandom_range(0, 5))
					add_pair(1'b1);
				add_pair(1'b0);
				glyph_q[glyph_q.size()-2] = 8'h00;
				glyph_q[glyph_q.size()-1] = 8'h00;
			end else if (pick == 13) begin
				glyph_q.push_back(8'(CMD_BULGE_SEQ));
				repeat ($urandom_range(0, 4)) begin
					add_pair(1'b1);
					glyph_q.push_back(8'($urandom));
				end
				glyph_q.push_back(8'h00);
				glyph_q.push_back(8'h00);
			end else if (pick == 14) begin
				arc = $urandom_range(0, 2);
				glyph_q.push_back(8'(arc == 0 ? CMD_OCT_ARC : arc == 1 ? CMD_FRAC_ARC
					: CMD_BULGE_ARC));
				repeat (arc == 0 ? 2 : arc == 1 ? 5 : 3)
					glyph_q.push_back(8'($urandom));
			end else if (pick == 15) begin
				glyph_q.push_back(8'($urandom_range(0, 1) ? CMD_SCALE_DIV : CMD_SCALE_MUL));
				glyph_q.push_back(8'($urandom));
			end else if (pick <= 17) begin
				glyph_q.push_back(8'(CMD_SKIP));
			end else begin
				glyph_q.push_back(8'($urandom_range(0, 1) ? CMD_SUBSHAPE : CMD_NOP));
			end
		end
		if ($urandom_range(0, 4) != 0) begin
			glyph_q.push_back(8'(CMD_END));
			// bytes after the end code are ignored up to the last one
			repeat ($urandom_range(0, 3))
				glyph_q.push_back(8'($urandom));
		end else begin
			// cut the definition short, possibly inside an operand run
			repeat ($urandom_range(0, 3))
				if (glyph_q.size() > 1)
					void'(glyph_q.pop_back());
		end
		if (glyph_q.size() == 0)
			glyph_q.push_back(8'($urandom));
	endfunction

	initial begin
		logic [CFG_DATA_W-1:0] org_x;
		logic [CFG_DATA_W-1:0] org_y;
		int unsigned           phase_start;
		int                    drain;

		repeat (9)
			@(negedge clk);
		arst_n = 1'b1;

		// directed, reset origin: pen down, long vector, signed extremes of an
		// offset, full stack push, pop with pen down, a pair series, end code
		// followed by an ignored byte
		glyph_q = '{8'(CMD_PEN_DOWN), 8'hF0, 8'(CMD_XY), 8'h80, 8'h7F,
			8'(CMD_PUSH), 8'(CMD_PUSH), 8'(CMD_PUSH), 8'(CMD_PUSH), 8'(CMD_PUSH),
			8'(CMD_POP), 8'(CMD_XY_SEQ), 8'h7F, 8'h80, 8'h00, 8'h00,
			8'(CMD_END), 8'(CMD_PEN_UP)};
		play_glyph();
		// empty pop, operand-only codes, bulge series, a skipped skip, then a
		// definition that stops inside an operand run
		glyph_q = '{8'(CMD_POP), 8'(CMD_SCALE_DIV), 8'h00, 8'(CMD_SCALE_MUL), 8'hFF,
			8'(CMD_SUBSHAPE), 8'(CMD_NOP), 8'(CMD_OCT_ARC), 8'h01, 8'h02,
			8'(CMD_BULGE_ARC), 8'h00, 8'h00, 8'h00,
			8'(CMD_BULGE_SEQ), 8'h01, 8'hFF, 8'h7F, 8'h00, 8'h00,
			8'(CMD_SKIP), 8'(CMD_SKIP), 8'(CMD_PEN_DOWN), 8'h2C, 8'(CMD_SKIP), 8'h1F,
			8'(CMD_FRAC_ARC), 8'h00, 8'h01};
		play_glyph();
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					org_x = 16'h7FFF;
					org_y = 16'h8000;
				end
				1: begin
					org_x = 16'h8000;
					org_y = 16'h7FFF;
				end
				2: begin
					org_x = 16'h0000;
					org_y = 16'h0000;
				end
				3: begin
					org_x = 16'hFFFF;
					org_y = 16'($urandom);
				end
				default: begin
					org_x = 16'($urandom);
					org_y = 16'($urandom);
				end
			endcase
			write_reg(REG_ORIGIN_X, org_x);
			write_reg(REG_ORIGIN_Y, org_y);
			// indexes past the last register must be dropped
			if (phase % 2 == 1)
				write_reg(CFG_IDX_W'($urandom_range(REG_ORIGIN_Y + 1, (1 << CFG_IDX_W) - 1)),
					16'($urandom));
			settings_run++;

			phase_start = bytes_sent;
			while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
				compose_glyph();
				play_glyph();
				if ($urandom_range(0, 29) == 0)
					settle();
			end
			settle();
		end

		// final drain, bounded
		drain = 0;
		while (strokes_due != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (4)
			@(negedge clk);
		final_check = 1'b1;
		repeat (2)
			@(negedge clk);

		$display("%0d shape bytes in %0d glyphs over %0d origin settings", bytes_sent,
			glyphs_sent, settings_run);
		$display("%0d strokes compared, %0d failures", strokes_checked, fail_count);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
